FILE: rtl/core/npcf_pkg.sv
// Shared types and constants for the neighbor pair cutoff filter.
package npcf_pkg;

   localparam int ATOM_INDEX_BITS = 20;
   localparam int COORD_BITS      = 32;
   localparam int CUTOFF_BITS     = 63;
   localparam int OWNED_END_BITS  = 21;
   localparam int REF_BITS        = 22;
   localparam int TOTAL_BITS      = 11;
   localparam int SQUARE_BITS     = 2 * COORD_BITS;
   localparam int CSR_INDEX_BITS  = 2;
   localparam int QUEUE_DEPTH     = 4;
   localparam int QUEUE_PTR_BITS  = $clog2(QUEUE_DEPTH);

   localparam logic [CSR_INDEX_BITS-1:0] CSR_CUTOFF_SQUARED = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_OWNED_FIRST    = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_OWNED_END      = 2'd2;

   localparam logic OPCODE_CENTER    = 1'b0;
   localparam logic OPCODE_CANDIDATE = 1'b1;

   typedef struct packed {
      logic                          opcode;
      logic [ATOM_INDEX_BITS-1:0]    atom_index;
      logic signed [COORD_BITS-1:0]  pos_x;
      logic signed [COORD_BITS-1:0]  pos_y;
      logic signed [COORD_BITS-1:0]  pos_z;
      logic                          final_candidate;
   } npcf_req_type;

   typedef struct packed {
      logic                      accepted;
      logic [REF_BITS-1:0]       neighbor_ref;
      logic                      is_local;
      logic [TOTAL_BITS-1:0]     local_total;
      logic [TOTAL_BITS-1:0]     remote_total;
      logic                      list_end;
   } npcf_rsp_type;

   // Classified item handed from the front to the back.
   typedef struct packed {
      logic                       is_center;
      logic                       skip;
      logic                       owned;
      logic [ATOM_INDEX_BITS-1:0] index;
      logic                       list_end;
      logic [COORD_BITS-1:0]      mag_x;
      logic [COORD_BITS-1:0]      mag_y;
      logic [COORD_BITS-1:0]      mag_z;
   } npcf_task_type;

endpackage

FILE: rtl/core/neighbor_pair_cutoff_filter_core.sv
// A candidate's result passes through the queue, square, sum and result registers.
// Throughput: one item per cycle until result-side stalls fill the four-entry queue.
// Center items clear the tallies in order with candidates and give no result.
// Each axis square uses its own 32x32 multiplier stage.
// Synchronous active-high reset clears the center, tallies, queue and config registers.
module neighbor_pair_cutoff_filter_core #(
   parameter int INDEX_BITS     = 20,
   parameter int MAX_CANDIDATES = 1024
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  npcf_pkg::npcf_req_type              req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output npcf_pkg::npcf_rsp_type              rsp_data,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [npcf_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [npcf_pkg::CUTOFF_BITS-1:0]    csr_data
);
   import npcf_pkg::*;

   logic [CUTOFF_BITS-1:0]     cutoff_ff, cutoff_in;
   logic [ATOM_INDEX_BITS-1:0] owned_first_ff, owned_first_in;
   logic [OWNED_END_BITS-1:0]  owned_end_ff, owned_end_in;

   logic                       q_push, q_full, q_pop, q_head_valid;
   npcf_task_type              q_push_data, q_head_data;

   assign csr_ready = 1'b1;

   always_comb begin
      cutoff_in      = cutoff_ff;
      owned_first_in = owned_first_ff;
      owned_end_in   = owned_end_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_CUTOFF_SQUARED: cutoff_in      = csr_data;
            CSR_OWNED_FIRST:    owned_first_in = csr_data[ATOM_INDEX_BITS-1:0];
            CSR_OWNED_END:      owned_end_in   = csr_data[OWNED_END_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cutoff_ff      <= '0;
         owned_first_ff <= '0;
         owned_end_ff   <= '0;
      end else begin
         cutoff_ff      <= cutoff_in;
         owned_first_ff <= owned_first_in;
         owned_end_ff   <= owned_end_in;
      end
   end

   npcf_front #(
      .INDEX_BITS (INDEX_BITS)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .owned_first (owned_first_ff),
      .owned_end   (owned_end_ff),
      .queue_full  (q_full),
      .push        (q_push),
      .task_out    (q_push_data)
   );

   npcf_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_data  (q_push_data),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (q_head_valid),
      .head_data  (q_head_data)
   );

   npcf_back #(
      .MAX_CANDIDATES (MAX_CANDIDATES)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .head_valid     (q_head_valid),
      .head_data      (q_head_data),
      .pop            (q_pop),
      .cutoff_squared (cutoff_ff),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_data       (rsp_data)
   );

endmodule

FILE: rtl/core/npcf_front.sv
// Front end: holds the center atom, classifies candidates, forms axis distances.
module npcf_front #(
   parameter int INDEX_BITS = 20
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  npcf_pkg::npcf_req_type               req_data,
   input  logic [npcf_pkg::ATOM_INDEX_BITS-1:0] owned_first,
   input  logic [npcf_pkg::OWNED_END_BITS-1:0]  owned_end,
   input  logic                                 queue_full,
   output logic                                 push,
   output npcf_pkg::npcf_task_type              task_out
);
   import npcf_pkg::*;

   localparam int IDX_USED = (INDEX_BITS < ATOM_INDEX_BITS) ? INDEX_BITS : ATOM_INDEX_BITS;
   localparam logic [ATOM_INDEX_BITS-1:0] IDX_MASK =
      ATOM_INDEX_BITS'((64'd1 << IDX_USED) - 64'd1);

   logic [ATOM_INDEX_BITS-1:0] center_id_ff, center_id_in;
   logic [COORD_BITS-1:0]      center_x_ff, center_x_in;
   logic [COORD_BITS-1:0]      center_y_ff, center_y_in;
   logic [COORD_BITS-1:0]      center_z_ff, center_z_in;

   logic [ATOM_INDEX_BITS-1:0] idx;
   logic                       owned;
   logic                       load_center;

   function automatic logic [COORD_BITS-1:0] axis_mag(input logic [COORD_BITS-1:0] a,
                                                      input logic [COORD_BITS-1:0] b);
      logic [COORD_BITS:0] d;
      logic [COORD_BITS:0] m;
      d = {a[COORD_BITS-1], a} - {b[COORD_BITS-1], b};
      m = d[COORD_BITS] ? (~d + 1'b1) : d;
      return m[COORD_BITS-1:0];
   endfunction

   assign req_ready   = !queue_full;
   assign push        = req_valid && req_ready;
   assign idx         = req_data.atom_index & IDX_MASK;
   assign load_center = push && (req_data.opcode == OPCODE_CENTER);
   assign owned       = (idx >= owned_first) && ({1'b0, idx} < owned_end);

   always_comb begin
      task_out.is_center = (req_data.opcode == OPCODE_CENTER);
      task_out.owned     = owned;
      task_out.skip      = owned && (idx <= center_id_ff);
      task_out.index     = idx;
      task_out.list_end  = req_data.final_candidate;
      task_out.mag_x     = axis_mag(center_x_ff, req_data.pos_x);
      task_out.mag_y     = axis_mag(center_y_ff, req_data.pos_y);
      task_out.mag_z     = axis_mag(center_z_ff, req_data.pos_z);
   end

   always_comb begin
      center_id_in = center_id_ff;
      center_x_in  = center_x_ff;
      center_y_in  = center_y_ff;
      center_z_in  = center_z_ff;
      if (load_center) begin
         center_id_in = idx;
         center_x_in  = req_data.pos_x;
         center_y_in  = req_data.pos_y;
         center_z_in  = req_data.pos_z;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         center_id_ff <= '0;
         center_x_ff  <= '0;
         center_y_ff  <= '0;
         center_z_ff  <= '0;
      end else begin
         center_id_ff <= center_id_in;
         center_x_ff  <= center_x_in;
         center_y_ff  <= center_y_in;
         center_z_ff  <= center_z_in;
      end
   end

endmodule

FILE: rtl/core/npcf_queue.sv
// Short queue of classified items between front and back.
module npcf_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  npcf_pkg::npcf_task_type push_data,
   output logic                    full,
   input  logic                    pop,
   output logic                    head_valid,
   output npcf_pkg::npcf_task_type head_data
);
   import npcf_pkg::*;

   npcf_task_type               entries_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_BITS-1:0]   head_ff, head_in;
   logic [QUEUE_PTR_BITS-1:0]   tail_ff, tail_in;
   logic [QUEUE_PTR_BITS:0]     count_ff, count_in;

   assign full       = (count_ff == (QUEUE_PTR_BITS+1)'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_data  = entries_ff[head_ff];

   always_comb begin
      head_in  = pop  ? head_ff + 1'b1 : head_ff;
      tail_in  = push ? tail_ff + 1'b1 : tail_ff;
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[tail_ff] <= push_data;
      end
   end

endmodule

FILE: rtl/core/npcf_back.sv
// Back end: squares, sums, cutoff compare, tallies and the result register.
module npcf_back #(
   parameter int MAX_CANDIDATES = 1024
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              head_valid,
   input  npcf_pkg::npcf_task_type           head_data,
   output logic                              pop,
   input  logic [npcf_pkg::CUTOFF_BITS-1:0]  cutoff_squared,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output npcf_pkg::npcf_rsp_type            rsp_data
);
   import npcf_pkg::*;

   localparam int TALLY_BITS = $clog2(MAX_CANDIDATES + 1);
   localparam logic [TALLY_BITS-1:0] TALLY_MAX = TALLY_BITS'(MAX_CANDIDATES);

   typedef struct packed {
      logic                       is_center;
      logic                       skip;
      logic                       owned;
      logic [ATOM_INDEX_BITS-1:0] index;
      logic                       list_end;
   } npcf_tag_type;

   logic                     advance;

   logic                     s1_valid_ff, s1_valid_in;
   npcf_tag_type             s1_tag_ff;
   logic [SQUARE_BITS-1:0]   s1_sq_x_ff, s1_sq_y_ff, s1_sq_z_ff;

   logic                     s2_valid_ff, s2_valid_in;
   npcf_tag_type             s2_tag_ff;
   logic [SQUARE_BITS:0]     s2_xy_ff;
   logic [SQUARE_BITS-1:0]   s2_z_ff;

   logic [SQUARE_BITS+1:0]   dist_sq;
   logic                     accept;

   logic [TALLY_BITS-1:0]    local_ff, local_in;
   logic [TALLY_BITS-1:0]    remote_ff, remote_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   npcf_rsp_type             rsp_data_ff, rsp_data_in;

   assign advance     = !rsp_valid_ff || rsp_ready;
   assign pop         = head_valid && advance;
   assign s1_valid_in = advance ? head_valid : s1_valid_ff;
   assign s2_valid_in = advance ? s1_valid_ff : s2_valid_ff;

   // A sum past 64 bits can never be within a 63-bit cutoff, so no clamp is needed.
   assign dist_sq = {1'b0, s2_xy_ff} + {2'b00, s2_z_ff};
   assign accept  = !s2_tag_ff.skip &&
                    (dist_sq <= (SQUARE_BITS+2)'(cutoff_squared));

   always_comb begin
      local_in     = local_ff;
      remote_in    = remote_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (advance) begin
         rsp_valid_in = 1'b0;
         if (s2_valid_ff) begin
            if (s2_tag_ff.is_center) begin
               local_in  = '0;
               remote_in = '0;
            end else begin
               if (accept && s2_tag_ff.owned && (local_ff < TALLY_MAX)) begin
                  local_in = local_ff + 1'b1;
               end
               if (accept && !s2_tag_ff.owned && (remote_ff < TALLY_MAX)) begin
                  remote_in = remote_ff + 1'b1;
               end
               rsp_valid_in              = 1'b1;
               rsp_data_in.accepted      = accept;
               rsp_data_in.neighbor_ref  = accept ? {s2_tag_ff.index, 2'b00} : '0;
               rsp_data_in.is_local      = accept && s2_tag_ff.owned;
               rsp_data_in.local_total   = TOTAL_BITS'(local_in);
               rsp_data_in.remote_total  = TOTAL_BITS'(remote_in);
               rsp_data_in.list_end      = s2_tag_ff.list_end;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         local_ff     <= '0;
         remote_ff    <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         local_ff     <= local_in;
         remote_ff    <= remote_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      if (advance) begin
         s1_tag_ff  <= '{is_center: head_data.is_center, skip: head_data.skip,
                         owned: head_data.owned, index: head_data.index,
                         list_end: head_data.list_end};
         s1_sq_x_ff <= SQUARE_BITS'(head_data.mag_x) * SQUARE_BITS'(head_data.mag_x);
         s1_sq_y_ff <= SQUARE_BITS'(head_data.mag_y) * SQUARE_BITS'(head_data.mag_y);
         s1_sq_z_ff <= SQUARE_BITS'(head_data.mag_z) * SQUARE_BITS'(head_data.mag_z);
         s2_tag_ff  <= s1_tag_ff;
         s2_xy_ff   <= {1'b0, s1_sq_x_ff} + {1'b0, s1_sq_y_ff};
         s2_z_ff    <= s1_sq_z_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
